// ----- rtl/sync_xor_frame_decoder_unit_macros.svh -----
// Assertion macros shared by the framer RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SYNC_XOR_FRAME_DECODER_UNIT_MACROS_SVH
`define SYNC_XOR_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define SXFD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define SXFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SXFD_ASSERT(lbl, cond, msg)
`define SXFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/sxfd_pkg.sv -----
package sxfd_pkg;

  // Frame lengths in bytes, including header, type and checksum.
  localparam logic [4:0] LONG_LEN  = 5'd17;
  localparam logic [4:0] SHORT_LEN = 5'd11;

  // Stored payload bytes per channel (frame bytes 2 and up, before the checksum).
  localparam int LONG_STORE  = 14;
  localparam int SHORT_STORE = 8;

  // Request queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HEADER = 2'd0;
  localparam cfg_idx_t CFG_TYPE_A = 2'd1;
  localparam cfg_idx_t CFG_TYPE_B = 2'd2;

  localparam logic [7:0] HEADER_RST = 8'hA5;
  localparam logic [7:0] TYPE_A_RST = 8'h81;
  localparam logic [7:0] TYPE_B_RST = 8'h82;

  localparam logic LINK_LONG  = 1'b0;
  localparam logic LINK_SHORT = 1'b1;

  // One request from the front part: either a payload byte to store or the
  // end of a frame with its checksum verdict.
  typedef struct packed {
    logic       done;
    logic       link;
    logic       ok;
    logic [3:0] idx;
    logic [7:0] data;
  } op_t;

  // Result of one framer step on the selected channel.
  typedef struct packed {
    logic [4:0] pos;
    logic [7:0] acc;
    logic       store;
    logic       done;
    logic       ok;
    logic [3:0] idx;
  } step_t;

endpackage

// ----- rtl/sxfd_stream_if.sv -----
interface sxfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_select;

  modport source (output valid, output rx_byte, output link_select, input ready);
  modport sink (input valid, input rx_byte, input link_select, output ready);
endinterface

interface sxfd_out_if;
  logic               valid;
  logic               ready;
  logic               frame_link;
  logic               frame_status;
  logic signed [31:0] field_one;
  logic signed [31:0] field_two;
  logic signed [15:0] field_three;
  logic signed [15:0] field_four;

  modport source (output valid, output frame_link, output frame_status,
                  output field_one, output field_two, output field_three,
                  output field_four, input ready);
  modport sink (input valid, input frame_link, input frame_status,
                input field_one, input field_two, input field_three,
                input field_four, output ready);
endinterface

// ----- rtl/sxfd_front.sv -----
`include "sync_xor_frame_decoder_unit_macros.svh"

module sxfd_front (
  input  logic                clk,
  input  logic                rst_n,
  sxfd_in_if.sink             in_ch,
  input  logic                cfg_we,
  input  sxfd_pkg::cfg_idx_t  cfg_index,
  input  logic [7:0]          cfg_wdata,
  output logic                push_valid,
  output sxfd_pkg::op_t       push_op,
  input  logic                push_ready
);
  import sxfd_pkg::*;

  logic [7:0] hdr_r, type_a_r, type_b_r;
  logic [4:0] pos_long_r, pos_long_nxt;
  logic [3:0] pos_short_r, pos_short_nxt;
  logic [7:0] xor_long_r, xor_long_nxt;
  logic [7:0] xor_short_r, xor_short_nxt;
  logic       accept;
  logic [4:0] p_sel;
  logic [7:0] acc_sel;
  logic [7:0] type_sel;
  logic [4:0] len_sel;
  step_t      st;

  function automatic step_t frame_step(input logic [4:0] p, input logic [7:0] acc,
                                       input logic [7:0] b, input logic [7:0] typ,
                                       input logic [7:0] hdr, input logic [4:0] len);
    step_t s;
    s.pos   = 5'd0;
    s.acc   = acc;
    s.store = 1'b0;
    s.done  = 1'b0;
    s.ok    = 1'b0;
    s.idx   = 4'(p - 5'd2);
    if (p == 5'd0 || p >= len) begin
      if (b == hdr) begin
        s.acc = b;
        s.pos = 5'd1;
      end
    end else if (p == 5'd1) begin
      if (b == typ) begin
        s.acc = acc ^ b;
        s.pos = 5'd2;
      end else if (b == hdr) begin
        s.acc = b;
        s.pos = 5'd1;
      end
    end else if (p < len - 5'd1) begin
      s.store = 1'b1;
      s.acc   = acc ^ b;
      s.pos   = p + 5'd1;
    end else begin
      s.done = 1'b1;
      s.ok   = (b == acc);
    end
    return s;
  endfunction

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid & push_ready;

  always_comb begin
    if (in_ch.link_select == LINK_SHORT) begin
      p_sel    = {1'b0, pos_short_r};
      acc_sel  = xor_short_r;
      type_sel = type_b_r;
      len_sel  = SHORT_LEN;
    end else begin
      p_sel    = pos_long_r;
      acc_sel  = xor_long_r;
      type_sel = type_a_r;
      len_sel  = LONG_LEN;
    end
    st = frame_step(p_sel, acc_sel, in_ch.rx_byte, type_sel, hdr_r, len_sel);
  end

  always_comb begin
    pos_long_nxt  = pos_long_r;
    pos_short_nxt = pos_short_r;
    xor_long_nxt  = xor_long_r;
    xor_short_nxt = xor_short_r;
    if (accept) begin
      if (in_ch.link_select == LINK_SHORT) begin
        pos_short_nxt = st.pos[3:0];
        xor_short_nxt = st.acc;
      end else begin
        pos_long_nxt = st.pos;
        xor_long_nxt = st.acc;
      end
    end
  end

  assign push_valid   = accept & (st.store | st.done);
  assign push_op.done = st.done;
  assign push_op.link = in_ch.link_select;
  assign push_op.ok   = st.ok;
  assign push_op.idx  = st.idx;
  assign push_op.data = in_ch.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_long_r  <= '0;
      pos_short_r <= '0;
      xor_long_r  <= '0;
      xor_short_r <= '0;
      hdr_r       <= HEADER_RST;
      type_a_r    <= TYPE_A_RST;
      type_b_r    <= TYPE_B_RST;
    end else begin
      pos_long_r  <= pos_long_nxt;
      pos_short_r <= pos_short_nxt;
      xor_long_r  <= xor_long_nxt;
      xor_short_r <= xor_short_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER: hdr_r    <= cfg_wdata;
          CFG_TYPE_A: type_a_r <= cfg_wdata;
          CFG_TYPE_B: type_b_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  `SXFD_ASSERT(a_pos_long_range, pos_long_r < LONG_LEN, "long framer position out of range")
  `SXFD_ASSERT(a_pos_short_range, {1'b0, pos_short_r} < SHORT_LEN,
               "short framer position out of range")

endmodule

// ----- rtl/sxfd_queue.sv -----
`include "sync_xor_frame_decoder_unit_macros.svh"

module sxfd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  sxfd_pkg::op_t push_op,
  output logic          push_ready,
  output logic          pop_valid,
  output sxfd_pkg::op_t pop_op,
  input  logic          pop_ready
);
  import sxfd_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  `SXFD_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH), "request queue overfilled")

endmodule

// ----- rtl/sxfd_back.sv -----
`include "sync_xor_frame_decoder_unit_macros.svh"

module sxfd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  sxfd_pkg::op_t pop_op,
  output logic          pop_ready,
  sxfd_out_if.source    out_ch
);
  import sxfd_pkg::*;

  logic [7:0]         long_store_r [LONG_STORE];
  logic [7:0]         short_store_r [SHORT_STORE];
  logic               out_valid_r, out_valid_nxt;
  logic               link_r, status_r;
  logic signed [31:0] f1_r, f2_r;
  logic signed [15:0] f3_r, f4_r;
  logic signed [31:0] f1_nxt, f2_nxt;
  logic signed [15:0] f3_nxt, f4_nxt;
  logic               pop;
  logic               load;

  assign pop_ready = !pop_op.done | !out_valid_r | out_ch.ready;
  assign pop       = pop_valid & pop_ready;
  assign load      = pop & pop_op.done;

  // Field extraction from the stored bytes; a bad checksum zeroes every field.
  always_comb begin
    f1_nxt = '0;
    f2_nxt = '0;
    f3_nxt = '0;
    f4_nxt = '0;
    if (pop_op.ok) begin
      if (pop_op.link == LINK_SHORT) begin
        f1_nxt = 32'(signed'({short_store_r[0], short_store_r[1]}));
        f2_nxt = 32'(signed'({short_store_r[2], short_store_r[3]}));
        f3_nxt = {short_store_r[4], short_store_r[5]};
        f4_nxt = {short_store_r[6], short_store_r[7]};
      end else begin
        f1_nxt = {long_store_r[2], long_store_r[3], long_store_r[4], long_store_r[5]};
        f2_nxt = {long_store_r[6], long_store_r[7], long_store_r[8], long_store_r[9]};
        f3_nxt = {long_store_r[10], long_store_r[11]};
        f4_nxt = {long_store_r[12], long_store_r[13]};
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !pop_op.done) begin
      if (pop_op.link == LINK_SHORT) begin
        short_store_r[pop_op.idx[2:0]] <= pop_op.data;
      end else begin
        long_store_r[pop_op.idx] <= pop_op.data;
      end
    end
    if (load) begin
      link_r   <= pop_op.link;
      status_r <= !pop_op.ok;
      f1_r     <= f1_nxt;
      f2_r     <= f2_nxt;
      f3_r     <= f3_nxt;
      f4_r     <= f4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_link   = link_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.field_one    = f1_r;
  assign out_ch.field_two    = f2_r;
  assign out_ch.field_three  = f3_r;
  assign out_ch.field_four   = f4_r;

  `SXFD_ASSERT_NEXT(a_done_shows_result, load, out_valid_r,
                    "completed frame did not reach the output register")

endmodule

// ----- rtl/sync_xor_frame_decoder_unit.sv -----
// The end-of-frame request passes through the request queue, then loads the output register.
// Throughput: one byte per cycle, sustained while the result side keeps up.
// The back end retires one queued request per cycle; a finished frame waits only for the output.
// Reset (rst_n low at a clock edge) clears framer positions, checksums, the request queue
// and the output valid, and restores the sync and type registers to their defaults.
// Stored payload bytes are not cleared; every frame writes its own before it completes.

module sync_xor_frame_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  sxfd_in_if.sink            in_ch,
  sxfd_out_if.source         out_ch,
  input  logic               cfg_we,
  input  sxfd_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import sxfd_pkg::*;

  // The front end owns the two framers (position counter and running XOR per
  // channel) and the configuration registers. Each accepted byte either moves
  // a hunt forward and produces nothing, or becomes one request: a payload
  // byte to store, or an end-of-frame marker carrying the checksum verdict.
  logic push_valid, push_ready;
  op_t  push_op;

  // The queue decouples the two parts, so bytes keep flowing in, until it fills, while a
  // finished frame is still waiting for the result side to take it.
  logic pop_valid, pop_ready;
  op_t  pop_op;

  sxfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready)
  );

  sxfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop_ready  (pop_ready)
  );

  // The back end writes payload bytes into the per-channel byte stores and, on
  // an end-of-frame request, assembles the big-endian fields into the output
  // register. Requests are retired in order, so all bytes of a frame are in
  // place before its end marker is handled.
  sxfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_op    (pop_op),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
